// ----- hw/rtl/srdq_pkg.sv -----
// Package: constants, payload structs and controller/datapath interface types.
package srdq_pkg;
  localparam int PORT_COUNT  = 4;
  localparam int QUEUE_DEPTH = 8;
  localparam int PW = $clog2(PORT_COUNT);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int SW = PW + QW;
  localparam int SLOTS = PORT_COUNT * QUEUE_DEPTH;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = 128;

  localparam logic [2:0] CFG_PORTS = 3'd0;
  localparam logic [2:0] CFG_NPE   = 3'd1;
  localparam logic [2:0] CFG_LIMIT = 3'd2;
  localparam logic [2:0] CFG_LAT   = 3'd3;
  localparam logic [2:0] CFG_MASK  = 3'd4;

  localparam logic [2:0] K_FWD      = 3'd0;
  localparam logic [2:0] K_QUEUED   = 3'd1;
  localparam logic [2:0] K_DROP_UR  = 3'd2;
  localparam logic [2:0] K_DROP_FUL = 3'd3;
  localparam logic [2:0] K_REL      = 3'd4;
  localparam logic [2:0] K_REL_DISC = 3'd5;
  localparam logic [2:0] K_TICK     = 3'd6;

  localparam logic CMD_SPIKE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] dest_neuron;
    logic [31:0] node_hint;
    logic [31:0] spike_payload;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  port;
    logic [31:0] out_neuron;
    logic [31:0] out_node;
    logic [31:0] out_payload;
    logic [31:0] forwarded_total;
    logic [31:0] dropped_total;
    logic [3:0]  queue_peak;
    logic        last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic          load;       // capture input word
    logic          div_start;
    logic          spike_res;  // finish spike: emit its result
    logic          tick_inc;   // advance cycle count
    logic [PW-1:0] scan_port;
    logic          release_hd; // pop head and emit release
    logic          tick_done;  // emit tick done
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic is_spike;
    logic head_ok;    // queue non-empty at scan_port and port active
    logic head_ready; // read head is ready (valid after read)
    logic out_full;
  } sts_t;
endpackage

// ----- hw/rtl/srdq_ram.sv -----
// Generic single-port-write, registered-read RAM.
module srdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/srdq_div.sv -----
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
module srdq_div import srdq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem, quotient[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 6'd32;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
      end else begin
        rem <= {rem[30:0], quotient[31]};
      end
      quotient <= {quotient[30:0], !trial[32]};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- hw/rtl/srdq_dp.sv -----
// Datapath: config, counters, queue pointers, entry RAM, divider, output register.
module srdq_dp import srdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  in_word_t  in_word,
  input  ctl_t      ctl,
  output sts_t      sts,
  output out_word_t out_word,
  output logic      out_valid,
  input  logic      out_ready
);
  logic [2:0]  ports_in_use;
  logic [31:0] npe;
  logic [3:0]  qlimit;
  logic [15:0] latency;
  logic [3:0]  mask;

  logic [31:0] cycle_count, fwd_cnt, drop_cnt;
  logic [3:0]  peak;
  logic [QW-1:0] head [PORT_COUNT];
  logic [CW-1:0] count [PORT_COUNT];
  in_word_t    cur;

  logic        div_busy;
  logic [31:0] quo;

  logic        ram_we;
  logic [SW-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      ports_in_use <= 3'd2;
      npe          <= '0;
      qlimit       <= '0;
      latency      <= '0;
      mask         <= 4'hf;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PORTS: ports_in_use <= cfg_data[2:0];
        CFG_NPE:   npe          <= cfg_data;
        CFG_LIMIT: qlimit       <= cfg_data[3:0];
        CFG_LAT:   latency      <= cfg_data[15:0];
        CFG_MASK:  mask         <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  srdq_div u_div (
    .clk(clk), .rst(rst), .start(ctl.div_start), .dividend(cur.dest_neuron),
    .divisor(npe), .busy(div_busy), .quotient(quo)
  );

  // active port count clipped to PORT_COUNT
  logic [4:0] np;
  assign np = ({2'b0, ports_in_use} > 5'(PORT_COUNT)) ? 5'(PORT_COUNT) : {2'b0, ports_in_use};
  logic [CW-1:0] lim;
  assign lim = (qlimit == 4'd0 || 32'(qlimit) > QUEUE_DEPTH) ? CW'(QUEUE_DEPTH) : CW'(qlimit);

  // spike classification
  logic          routable;
  logic [PW-1:0] sp;
  assign sp = quo[PW-1:0];
  assign routable = (npe != 32'd0) && (quo < 32'(np)) && (quo < 32'd4) && mask[quo[1:0]];
  logic full;
  assign full = count[sp] >= lim;

  // scan head
  logic [PW-1:0] spt;
  assign spt = ctl.scan_port;
  logic [31:0] rd_ready_time;
  assign rd_ready_time = rdata[31:0];
  logic [31:0] wait_age;
  assign wait_age = cycle_count - rd_ready_time;
  logic conn_scan;
  assign conn_scan = (32'(spt) < 32'd4) && mask[2'(spt)];

  assign raddr = {spt, head[spt]};
  assign ram_we = ctl.spike_res && routable && (latency != 16'd0) && !full;
  assign waddr = {sp, QW'(32'(head[sp]) + 32'(count[sp]))};
  assign wdata = {cur.dest_neuron, cur.node_hint, cur.spike_payload,
                  cycle_count + {16'd0, latency}};

  srdq_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign sts.div_busy   = div_busy;
  assign sts.is_spike   = (cur.cmd == CMD_SPIKE);
  assign sts.head_ok    = (5'(spt) < np) && (count[spt] != '0);
  assign sts.head_ready = !wait_age[31];
  assign sts.out_full   = out_valid && !out_ready;

  logic [CW-1:0] newc;
  assign newc = count[sp] + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_count <= '0;
      fwd_cnt     <= '0;
      drop_cnt    <= '0;
      peak        <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (ctl.spike_res || ctl.release_hd || ctl.tick_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.tick_inc) begin
        cycle_count <= cycle_count + 32'd1;
      end
      if (ctl.spike_res) begin
        out_word.out_neuron   <= cur.dest_neuron;
        out_word.out_node     <= cur.node_hint;
        out_word.out_payload  <= cur.spike_payload;
        out_word.last         <= 1'b1;
        if (!routable) begin
          drop_cnt <= drop_cnt + 32'd1;
          out_word.kind            <= K_DROP_UR;
          out_word.port            <= 2'd0;
          out_word.forwarded_total <= fwd_cnt;
          out_word.dropped_total   <= drop_cnt + 32'd1;
          out_word.queue_peak      <= peak;
        end else if (latency == 16'd0) begin
          fwd_cnt <= fwd_cnt + 32'd1;
          out_word.kind            <= K_FWD;
          out_word.port            <= 2'(sp);
          out_word.forwarded_total <= fwd_cnt + 32'd1;
          out_word.dropped_total   <= drop_cnt;
          out_word.queue_peak      <= peak;
        end else if (full) begin
          drop_cnt <= drop_cnt + 32'd1;
          out_word.kind            <= K_DROP_FUL;
          out_word.port            <= 2'(sp);
          out_word.forwarded_total <= fwd_cnt;
          out_word.dropped_total   <= drop_cnt + 32'd1;
          out_word.queue_peak      <= peak;
        end else begin
          count[sp] <= newc;
          out_word.kind            <= K_QUEUED;
          out_word.port            <= 2'(sp);
          out_word.forwarded_total <= fwd_cnt;
          out_word.dropped_total   <= drop_cnt;
          if (4'(newc) > peak) begin
            peak <= 4'(newc);
            out_word.queue_peak <= 4'(newc);
          end else begin
            out_word.queue_peak <= peak;
          end
        end
      end
      if (ctl.release_hd) begin
        head[spt]  <= head[spt] + QW'(1);
        count[spt] <= count[spt] - CW'(1);
        out_word.port        <= 2'(spt);
        out_word.out_neuron  <= rdata[127:96];
        out_word.out_node    <= rdata[95:64];
        out_word.out_payload <= rdata[63:32];
        out_word.dropped_total <= drop_cnt;
        out_word.queue_peak  <= peak;
        out_word.last        <= 1'b0;
        if (conn_scan) begin
          fwd_cnt <= fwd_cnt + 32'd1;
          out_word.forwarded_total <= fwd_cnt + 32'd1;
          out_word.kind <= K_REL;
        end else begin
          out_word.forwarded_total <= fwd_cnt;
          out_word.kind <= K_REL_DISC;
        end
      end
      if (ctl.tick_done) begin
        out_word  <= '{kind: K_TICK, port: 2'd0, out_neuron: '0, out_node: '0,
                       out_payload: '0, forwarded_total: fwd_cnt,
                       dropped_total: drop_cnt, queue_peak: peak, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur <= in_word;
    end
  end
endmodule

// ----- hw/rtl/srdq_ctrl.sv -----
// Controller: sequences spike division and tick queue walk.
module srdq_ctrl import srdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);
  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SPK, S_SCAN, S_READ, S_CHK, S_DONE
  } state_t;

  state_t        state;
  logic [PW:0]   port;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    ctl.scan_port = port[PW-1:0];
    ctl.load = in_valid && in_ready;
    ctl.div_start = (state == S_DIV) && !sts.div_busy && sts.is_spike && (port == '0);
    ctl.spike_res = (state == S_SPK) && !sts.out_full;
    ctl.tick_inc  = (state == S_SCAN) && (port == '1);
    ctl.release_hd = (state == S_CHK) && sts.head_ready && !sts.out_full;
    ctl.tick_done  = (state == S_DONE) && !sts.out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      port  <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          state <= S_DIV;
          port  <= '0;
        end
        S_DIV: begin
          // port reused as a one-shot flag: 0 = start divider, 1 = wait
          if (!sts.is_spike) begin
            state <= S_SCAN;
            port  <= '1;
          end else if (port == '0) begin
            port <= {{PW{1'b0}}, 1'b1};
          end else if (!sts.div_busy) begin
            state <= S_SPK;
          end
        end
        S_SPK: if (!sts.out_full) begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          // all-ones marks the cycle-count bump before the walk
          if (port == '1) begin
            port <= '0;
          end else if (32'(port) >= PORT_COUNT) begin
            state <= S_DONE;
          end else if (sts.head_ok) begin
            state <= S_READ;
          end else begin
            port <= port + (PW+1)'(1);
          end
        end
        S_READ: state <= S_CHK;
        S_CHK: begin
          if (!sts.head_ready) begin
            port  <= port + (PW+1)'(1);
            state <= S_SCAN;
          end else if (!sts.out_full) begin
            state <= S_SCAN;
          end
        end
        S_DONE: if (!sts.out_full) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/spike_router_delay_queues_unit.sv -----
// Top level: spike router with per-port delay queues.
// Usage:
//   Input channel (in_valid/in_ready, in_data) takes one word: a spike
//   arrival (cmd 0) or a tick (cmd 1). One word is worked at a time.
//   Output channel (out_valid/out_ready, out_data) carries result words.
//   Spike: one result word, from the 32-step bit-serial divider that picks
//   the port; the next word is taken only once that result is registered.
//   Tick: one word per released entry, then a tick-done word with last=1.
//   The controller walks the ports, reading each head from the single-read-port
//   entry RAM; all PORT_COUNT ports are scanned.
//   Config: cfg_we/cfg_index/cfg_data, written while idle, no wait.
//   Reset (rst, sync): config to defaults, queues empty, counters zero.
//   Output stall: the result register holds and the controller waits.
//   Queue entries live in one RAM of PORT_COUNT*QUEUE_DEPTH rows.
module spike_router_delay_queues_unit import srdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  ctl_t ctl;
  sts_t sts;

  srdq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .ctl(ctl)
  );

  srdq_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_word(in_data), .ctl(ctl), .sts(sts), .out_word(out_data),
    .out_valid(out_valid), .out_ready(out_ready)
  );
endmodule

// ----- verif/spike_router_delay_queues_unit_test.sv -----
// Testbench for the spike router with per-port delay queues.
`timescale 1ns / 100ps

module spike_router_delay_queues_unit_test;
  import srdq_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  spike_router_delay_queues_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the router: config, queues, counters.
  logic [2:0]  sh_ports;
  logic [31:0] sh_npe;
  logic [3:0]  sh_limit;
  logic [15:0] sh_lat;
  logic [3:0]  sh_mask;
  logic [31:0] sh_cycle;
  logic [31:0] q_neu [SLOTS];
  logic [31:0] q_node [SLOTS];
  logic [31:0] q_pay [SLOTS];
  logic [31:0] q_rdy [SLOTS];
  int unsigned q_head [PORT_COUNT];
  int unsigned q_cnt [PORT_COUNT];
  int unsigned sh_peak;
  logic [31:0] sh_fwd;
  logic [31:0] sh_drop;

  out_word_t pending_results[$];

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned words_seen = 0;
  int unsigned released_seen = 0;
  int unsigned idle_cycles = 0;
  int          send_idle_pct = 0;  // sender gap odds in percent
  int          recv_stall_pct = 0; // receiver stall odds in percent
  int          hold_off = 0;       // long receiver stall, cycles left
  localparam int WATCHDOG = 20000;

  task automatic shadow_reset();
    sh_ports = 3'd2; sh_npe = '0; sh_limit = '0; sh_lat = '0; sh_mask = 4'hf;
    sh_cycle = '0; sh_peak = 0; sh_fwd = '0; sh_drop = '0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      q_head[p] = 0; q_cnt[p] = 0;
    end
  endtask

  function automatic bit port_linked(int unsigned p);
    return p < 4 && sh_mask[p];
  endfunction

  function automatic out_word_t make_result(logic [2:0] kind, logic [1:0] port,
      logic [31:0] neu, logic [31:0] node, logic [31:0] pay, logic last);
    out_word_t r;
    r.kind = kind; r.port = port; r.out_neuron = neu; r.out_node = node;
    r.out_payload = pay; r.forwarded_total = sh_fwd; r.dropped_total = sh_drop;
    r.queue_peak = sh_peak > 15 ? 4'd15 : sh_peak[3:0]; r.last = last;
    return r;
  endfunction

  function automatic void queue_result(out_word_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Work out the result words one input word causes; updates the shadow.
  task automatic route_word(in_word_t w);
    int unsigned np, lim, port, slot;
    logic [31:0] q;
    np = sh_ports > PORT_COUNT ? PORT_COUNT : sh_ports;
    if (w.cmd == CMD_SPIKE) begin
      if (sh_npe == 0) begin
        sh_drop++;
        queue_result(make_result(K_DROP_UR, 2'd0, w.dest_neuron,
                                 w.node_hint, w.spike_payload, 1'b1));
        return;
      end
      q = w.dest_neuron / sh_npe;
      if (q >= np || !port_linked(q)) begin
        sh_drop++;
        queue_result(make_result(K_DROP_UR, 2'd0, w.dest_neuron,
                                 w.node_hint, w.spike_payload, 1'b1));
        return;
      end
      port = q;
      if (sh_lat == 0) begin
        sh_fwd++;
        queue_result(make_result(K_FWD, port[1:0], w.dest_neuron,
                                 w.node_hint, w.spike_payload, 1'b1));
        return;
      end
      lim = (sh_limit == 0 || sh_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : sh_limit;
      if (q_cnt[port] >= lim) begin
        sh_drop++;
        queue_result(make_result(K_DROP_FUL, port[1:0], w.dest_neuron,
                                 w.node_hint, w.spike_payload, 1'b1));
        return;
      end
      slot = port * QUEUE_DEPTH + (q_head[port] + q_cnt[port]) % QUEUE_DEPTH;
      q_neu[slot] = w.dest_neuron; q_node[slot] = w.node_hint;
      q_pay[slot] = w.spike_payload; q_rdy[slot] = sh_cycle + 32'(sh_lat);
      q_cnt[port]++;
      if (q_cnt[port] > sh_peak) sh_peak = q_cnt[port];
      queue_result(make_result(K_QUEUED, port[1:0], w.dest_neuron,
                               w.node_hint, w.spike_payload, 1'b1));
      return;
    end
    sh_cycle++;
    for (int unsigned p = 0; p < np; p++) begin
      while (q_cnt[p] > 0) begin
        logic [31:0] age;
        logic [2:0] kind;
        slot = p * QUEUE_DEPTH + q_head[p];
        age = sh_cycle - q_rdy[slot];
        if (age[31]) break;
        q_head[p] = (q_head[p] + 1) % QUEUE_DEPTH;
        q_cnt[p]--;
        if (port_linked(p)) begin
          sh_fwd++; kind = K_REL;
        end else begin
          kind = K_REL_DISC;
        end
        queue_result(make_result(kind, p[1:0], q_neu[slot], q_node[slot],
                                 q_pay[slot], 1'b0));
      end
    end
    queue_result(make_result(K_TICK, 2'd0, '0, '0, '0, 1'b1));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // Receiver: stalls at random or for a long hold-off; checks each word.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word kind", 32'(out_data.kind), '0);
        end else begin
          out_word_t e;
          e = pending_results[0];
          pending_results.delete(0);
          if (out_data.kind == K_REL) released_seen++;
          if (out_data.kind != e.kind)
            report_mismatch("kind", 32'(out_data.kind), 32'(e.kind));
          if (out_data.port != e.port)
            report_mismatch("port", 32'(out_data.port), 32'(e.port));
          if (out_data.out_neuron != e.out_neuron)
            report_mismatch("out_neuron", out_data.out_neuron, e.out_neuron);
          if (out_data.out_node != e.out_node)
            report_mismatch("out_node", out_data.out_node, e.out_node);
          if (out_data.out_payload != e.out_payload)
            report_mismatch("out_payload", out_data.out_payload, e.out_payload);
          if (out_data.forwarded_total != e.forwarded_total)
            report_mismatch("forwarded_total", out_data.forwarded_total, e.forwarded_total);
          if (out_data.dropped_total != e.dropped_total)
            report_mismatch("dropped_total", out_data.dropped_total, e.dropped_total);
          if (out_data.queue_peak != e.queue_peak)
            report_mismatch("queue_peak", 32'(out_data.queue_peak), 32'(e.queue_peak));
          if (out_data.last != e.last)
            report_mismatch("last", 32'(out_data.last), 32'(e.last));
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Send one word; predicts its results at acceptance. Valid stays high
  // after acceptance so back-to-back words need no gap.
  task automatic send_word(in_word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    route_word(w);
    words_sent++;
  endtask

  task automatic send_spike(logic [31:0] neu, logic [31:0] node, logic [31:0] pay);
    in_word_t w;
    w.cmd = CMD_SPIKE; w.dest_neuron = neu; w.node_hint = node; w.spike_payload = pay;
    send_word(w);
  endtask

  task automatic send_tick();
    in_word_t w;
    w.cmd = CMD_TICK; w.dest_neuron = $urandom; w.node_hint = $urandom;
    w.spike_payload = $urandom;
    send_word(w);
  endtask

  // Stop offering words and wait until every expected result is in.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Drain, then let the block settle before touching config.
  task automatic wait_idle();
    drain();
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_PORTS: sh_ports = val[2:0];
      CFG_NPE:   sh_npe = val;
      CFG_LIMIT: sh_limit = val[3:0];
      CFG_LAT:   sh_lat = val[15:0];
      CFG_MASK:  sh_mask = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [2:0] ports, logic [31:0] npe, logic [3:0] lim,
                            logic [15:0] lat, logic [3:0] mask);
    wait_idle();
    write_reg(CFG_PORTS, 32'(ports));
    write_reg(CFG_NPE, npe);
    write_reg(CFG_LIMIT, 32'(lim));
    write_reg(CFG_LAT, 32'(lat));
    write_reg(CFG_MASK, 32'(mask));
    cfg_we <= 1'b0;
  endtask

  // Directed: reset defaults drop all, extremes, immediate and queued paths.
  task automatic test_directed();
    send_spike('0, '0, '0);                           // divisor zero
    send_spike('1, '1, '1);
    send_tick();
    set_config(3'd7, 32'd1, 4'd0, 16'd0, 4'hf);       // ports clamp to 4
    send_spike(32'd3, 32'h1234, 32'hdead_beef);       // forward now
    send_spike(32'd4, '0, '0);                        // out of range
    set_config(3'd4, 32'd1, 4'd0, 16'd0, 4'b1101);
    send_spike(32'd1, '1, '1);                        // unconnected
    set_config(3'd0, 32'd1, 4'd0, 16'd0, 4'hf);       // zero ports
    send_spike('0, '0, '0);
    send_tick();
    set_config(3'd4, 32'hffff_ffff, 4'd15, 16'd1, 4'hf); // limit clamp
    send_spike('1, 32'h5, 32'h6);                     // port 1 of huge divisor
    send_spike(32'h7fff_ffff, 32'h1, 32'h2);
    send_tick();
    set_config(3'd2, 32'd1, 4'd2, 16'd2, 4'b0001);
    send_spike(32'd0, 32'h11, 32'h22);
    send_spike(32'd0, 32'h33, 32'h44);
    send_spike(32'd0, 32'h55, 32'h66);                // queue full
    send_tick();
    send_tick();
    // Queue on port 1 then disconnect it: release is discarded.
    set_config(3'd2, 32'd1, 4'd0, 16'd1, 4'b0011);
    send_spike(32'd1, 32'h77, 32'h88);
    set_config(3'd2, 32'd1, 4'd0, 16'd1, 4'b0001);
    send_tick();
    // Entry parked on an inactive port until it comes back.
    set_config(3'd2, 32'd1, 4'd0, 16'd1, 4'hf);
    send_spike(32'd1, 32'h99, 32'haa);
    set_config(3'd1, 32'd1, 4'd0, 16'd1, 4'hf);
    send_tick();
    set_config(3'd2, 32'd1, 4'd0, 16'd1, 4'hf);
    send_tick();
    set_config(3'd4, 32'd1, 4'd0, 16'hffff, 4'hf);    // longest latency
    send_spike(32'd2, 32'h1, 32'h1);
    send_tick();
  endtask

  // Random phase: mostly routable spikes with ticks mixed in.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      int unsigned r;
      r = $urandom_range(99);
      if (r < 30) send_tick();
      else if (r < 85) send_spike($urandom_range(4 * sh_npe + 1), $urandom, $urandom);
      else send_spike($urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_random_phases();
    set_config(3'd4, 32'd16, 4'd0, 16'd2, 4'hf);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(60);
    set_config(3'd3, 32'd5, 4'd4, 16'd1, 4'b1011);
    send_idle_pct = 45; recv_stall_pct = 0;
    test_random(60);
    set_config(3'd4, 32'd8, 4'd8, 16'd3, 4'b0111);
    send_idle_pct = 0; recv_stall_pct = 45;
    test_random(60);
    set_config(3'd4, 32'd3, 4'd0, 16'd0, 4'hf);
    send_idle_pct = 32; recv_stall_pct = 32;
    test_random(60);
  endtask

  // Long receiver hold-off while spikes pile up; then a full drain pause.
  task automatic test_backpressure();
    set_config(3'd4, 32'd1, 4'd0, 16'd0, 4'hf);
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 400;
    for (int i = 0; i < 6; i++) send_spike($urandom_range(3), $urandom, $urandom);
    drain();
    send_spike(32'd2, $urandom, $urandom);
  endtask

  initial begin
    shadow_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_idle();
    $display("sent %0d words, checked %0d results, %0d releases",
             words_sent, words_seen, released_seen);
    $display("covered drops, forwards, queue fill, discards, inactive ports, stalls");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
